// ===== rtl/fcsg_pkg.sv =====
package fcsg_pkg;

  localparam int COORD_W  = 15;
  localparam int RADIUS_W = 6;
  localparam int COLOR_W  = 32;
  localparam int SPAN_W   = 16;
  localparam int AREA_W   = 2 * RADIUS_W;
  localparam int ROOT_W   = RADIUS_W;
  localparam int DIGITS_PER_STAGE = ROOT_W / 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RADIUS_W-1:0]       radius_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic signed [SPAN_W-1:0]  span_coord_t;
  typedef logic [AREA_W-1:0]         area_t;
  typedef logic [ROOT_W-1:0]         root_t;

  // one span to be produced, as it travels down the pipeline
  typedef struct packed {
    coord_t  cx;
    coord_t  cy;
    radius_t r;
    color_t  color;
    radius_t d;
    logic    lower;
    logic    last;
  } span_job_t;

  // DIGITS_PER_STAGE digits of a restoring integer square root, starting at the digit in mask
  function automatic root_t sqrt_digits(area_t n, root_t root_in, root_t mask_in);
    root_t root;
    root_t mask;
    root_t trial;
    area_t sq;
    root = root_in;
    mask = mask_in;
    for (int i = 0; i < DIGITS_PER_STAGE; i++) begin
      trial = root | mask;
      sq = AREA_W'(trial) * AREA_W'(trial);
      if (sq <= n) begin
        root = trial;
      end
      mask = mask >> 1;
    end
    return root;
  endfunction

endpackage

// ===== rtl/circle_if.sv =====
interface circle_if;
  logic           valid;
  logic           ready;
  fcsg_pkg::coord_t  center_x;
  fcsg_pkg::coord_t  center_y;
  fcsg_pkg::radius_t circle_radius;
  fcsg_pkg::color_t  fill_color;

  modport source (output valid, center_x, center_y, circle_radius, fill_color,
                  input ready);
  modport sink   (input valid, center_x, center_y, circle_radius, fill_color,
                  output ready);
endinterface

// ===== rtl/span_if.sv =====
interface span_if;
  logic                   valid;
  logic                   ready;
  fcsg_pkg::span_coord_t  span_row;
  fcsg_pkg::span_coord_t  span_left;
  fcsg_pkg::span_coord_t  span_right;
  fcsg_pkg::color_t       span_color;
  logic                   last_span;

  modport source (output valid, span_row, span_left, span_right, span_color, last_span,
                  input ready);
  modport sink   (input valid, span_row, span_left, span_right, span_color, last_span,
                  output ready);
endinterface

// ===== rtl/filled_circle_span_generator.sv =====
// channel   dir  payload                                              role
// req       in   center_x, center_y, circle_radius, fill_color         one circle
// span      out  span_row, span_left, span_right, span_color, last_span one span
//
// while a circle is in work the request side is held (ready low): the sequencer
// issues one span per cycle while the span side does not stall, each into a five-stage
// pipeline (issue, area product, two square-root stages, span output register).
// rst is synchronous and clears the sequencer, the held request and all stage valid bits.
// a stall on the span side freezes every stage and span issue; an idle block still accepts a request.
module filled_circle_span_generator #(
  parameter int MAX_RADIUS = 32
) (
  input logic clk,
  input logic rst,
  circle_if.sink  req,
  span_if.source  span
);
  import fcsg_pkg::*;

  // pipeline advance
  logic en;
  assign en = !span.valid || span.ready;

  // sequencer state
  logic      busy;
  logic      side;
  radius_t   row_offset;
  span_job_t held;
  logic      issue_last;
  radius_t   rad_sat;

  assign req.ready  = !busy;
  assign issue_last = (row_offset >= held.r);
  assign rad_sat    = (req.circle_radius > RADIUS_W'(MAX_RADIUS)) ?
                      RADIUS_W'(MAX_RADIUS) : req.circle_radius;

  // stage registers
  logic      v0, v1, v2, v3, vout;
  span_job_t job0, job1, job2, job3;
  area_t     n1, n2, n3;
  root_t     root2, root3;

  // sequencer and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      side <= 1'b0;
      row_offset <= '0;
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        busy <= 1'b1;
        side <= 1'b0;
        row_offset <= RADIUS_W'(1);
      end else if (busy && en) begin
        if (issue_last) begin
          busy <= 1'b0;
        end else if (side) begin
          side <= 1'b0;
          row_offset <= row_offset + RADIUS_W'(1);
        end else begin
          side <= 1'b1;
        end
      end
      if (en) begin
        v0 <= busy;
        v1 <= v0;
        v2 <= v1;
        v3 <= v2;
        vout <= v3;
      end
    end
  end

  // held request
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (req.valid && req.ready) begin
      held.cx    <= req.center_x;
      held.cy    <= req.center_y;
      held.r     <= rad_sat;
      held.color <= req.fill_color;
      held.d     <= '0;
      held.lower <= 1'b0;
      held.last  <= 1'b0;
    end
  end

  // job for the span issued this cycle
  span_job_t issue_job;
  always_comb begin
    issue_job       = held;
    issue_job.d     = row_offset;
    issue_job.lower = side;
    issue_job.last  = issue_last;
  end

  // area product d*(2r-d), then the square root in two digit groups, one group per stage
  logic [AREA_W:0] prod;
  assign prod = (AREA_W+1)'(job0.d) *
                (AREA_W+1)'({1'b0, job0.r, 1'b0} - {2'b00, job0.d});

  always_ff @(posedge clk) begin
    if (en) begin
      job0 <= issue_job;

      job1 <= job0;
      n1   <= prod[AREA_W-1:0];

      job2  <= job1;
      n2    <= n1;
      root2 <= sqrt_digits(n1, '0, root_t'(1) << (ROOT_W - 1));

      job3  <= job2;
      n3    <= n2;
      root3 <= sqrt_digits(n2, root2, root_t'(1) << (DIGITS_PER_STAGE - 1));
    end
  end

  // span output register
  root_t       half;
  span_coord_t cx16, cy16, r16, d16, w16;
  assign half = job3.last ? job3.r : root3;
  assign cx16 = SPAN_W'(job3.cx);
  assign cy16 = SPAN_W'(job3.cy);
  assign r16  = span_coord_t'({{(SPAN_W-RADIUS_W){1'b0}}, job3.r});
  assign d16  = span_coord_t'({{(SPAN_W-RADIUS_W){1'b0}}, job3.d});
  assign w16  = span_coord_t'({{(SPAN_W-ROOT_W){1'b0}}, half});

  always_ff @(posedge clk) begin
    if (en) begin
      span.span_left  <= cx16 - w16;
      span.span_right <= cx16 + w16;
      span.span_color <= job3.color;
      span.last_span  <= job3.last;
      if (job3.last) begin
        span.span_row <= cy16;
      end else if (job3.lower) begin
        span.span_row <= cy16 - d16 + r16;
      end else begin
        span.span_row <= cy16 + d16 - r16;
      end
    end
  end

  assign span.valid = vout;

  // checks
  logic [AREA_W:0] sq3, sq3p;
  assign sq3  = (AREA_W+1)'(root3) * (AREA_W+1)'(root3);
  assign sq3p = ((AREA_W+1)'(root3) + 1'b1) * ((AREA_W+1)'(root3) + 1'b1);

  a_root_exact: assert property (@(posedge clk) disable iff (rst)
    v3 && !job3.last |-> (sq3 <= (AREA_W+1)'(n3)) && (sq3p > (AREA_W+1)'(n3)))
    else $error("square root stage result is not the floor root");

  a_root_upper: assert property (@(posedge clk) disable iff (rst)
    v2 |-> root2[DIGITS_PER_STAGE-1:0] == '0)
    else $error("first root stage set low digits");

  a_span_order: assert property (@(posedge clk) disable iff (rst)
    span.valid |-> span.span_right >= span.span_left)
    else $error("span right edge left of its left edge");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

import fcsg_pkg::*;

// one expected span as it should leave the block
typedef struct {
  span_coord_t row;
  span_coord_t left;
  span_coord_t right;
  color_t      color;
  logic        last;
} circle_span_t;

class span_scoreboard;
  localparam int MAX_RADIUS = 32;

  circle_span_t expected_spans[$];
  int           errors;

  function new();
    errors = 0;
  endfunction

  // work out every span of one accepted circle, in output order
  function void add_circle(coord_t x, coord_t y, radius_t r, color_t c);
    int xi;
    int yi;
    int rad;
    int area;
    int w;
    circle_span_t s;
    xi  = x;
    yi  = y;
    rad = r;
    if (rad > MAX_RADIUS) rad = MAX_RADIUS;
    s.color = c;
    s.last  = 1'b0;
    for (int d = 1; d < rad; d++) begin
      area = 2 * rad * d - d * d;
      w = 0;
      while ((w + 1) * (w + 1) <= area) w++;
      s.left  = span_coord_t'(xi - w);
      s.right = span_coord_t'(xi + w);
      s.row   = span_coord_t'(yi + d - rad);
      expected_spans.push_back(s);
      s.row   = span_coord_t'(yi - d + rad);
      expected_spans.push_back(s);
    end
    // center row closes the circle
    s.row   = span_coord_t'(yi);
    s.left  = span_coord_t'(xi - rad);
    s.right = span_coord_t'(xi + rad);
    s.last  = 1'b1;
    expected_spans.push_back(s);
  endfunction

  function void compare_field(string name, logic signed [63:0] exp_val,
                              logic signed [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s expected %0d got %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  // compare one output transaction with the oldest expected span
  function void check_span(span_coord_t row, span_coord_t left, span_coord_t right,
                           color_t color, logic last);
    circle_span_t e;
    if (expected_spans.size() == 0) begin
      $error("span with nothing expected: row %0d left %0d right %0d", row, left, right);
      errors++;
      return;
    end
    e = expected_spans.pop_front();
    compare_field("span_row", e.row, row);
    compare_field("span_left", e.left, left);
    compare_field("span_right", e.right, right);
    compare_field("span_color", e.color, color);
    compare_field("last_span", e.last, last);
  endfunction
endclass

module testbench;
  localparam int MAX_RADIUS     = 32;
  localparam int RANDOM_CIRCLES = 260;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 16;

  logic clk;
  logic rst;
  int   idle_cycles;

  circle_if req_ch ();
  span_if   span_ch ();

  span_scoreboard sb = new();

  filled_circle_span_generator #(
    .MAX_RADIUS(MAX_RADIUS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .span(span_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one circle and hold it until the block takes it
  task automatic send_circle(coord_t x, coord_t y, radius_t r, color_t c);
    req_ch.valid         <= 1'b1;
    req_ch.center_x      <= x;
    req_ch.center_y      <= y;
    req_ch.circle_radius <= r;
    req_ch.fill_color    <= c;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // mostly small circles, some large, a few above the radius limit
  task automatic send_random_circle();
    int pick;
    radius_t r;
    pick = $urandom_range(0, 99);
    if (pick < 55) r = radius_t'($urandom_range(0, 6));
    else if (pick < 85) r = radius_t'($urandom_range(7, 32));
    else if (pick < 93) r = radius_t'($urandom_range(33, 63));
    else r = (pick[0]) ? radius_t'(MAX_RADIUS) : radius_t'($urandom_range(0, 1));
    send_circle(coord_t'($urandom), coord_t'($urandom), r, color_t'($urandom));
  endtask

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.add_circle(req_ch.center_x, req_ch.center_y, req_ch.circle_radius,
                    req_ch.fill_color);
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && span_ch.valid && span_ch.ready)
      sb.check_span(span_ch.span_row, span_ch.span_left, span_ch.span_right,
                    span_ch.span_color, span_ch.last_span);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (span_ch.valid && span_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // receiver backpressure, switching between patterns
  initial begin
    int mode;
    int mode_left;
    int phase;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    span_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 200);
      end else begin
        mode_left--;
      end
      phase++;
      case (mode)
        0: span_ch.ready <= 1'b1;
        1: span_ch.ready <= ($urandom_range(0, 9) < 7);
        2: span_ch.ready <= ((phase % 5) < 3);
        default: span_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // reset, stimulus and end of run
  initial begin
    int burst;
    int gap;
    int sent;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.center_x      <= '0;
    req_ch.center_y      <= '0;
    req_ch.circle_radius <= '0;
    req_ch.fill_color    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, tiny circles, saturated radius
    send_circle(coord_t'(0), coord_t'(0), radius_t'(0), color_t'(32'h0000_0000));
    send_circle(coord_t'(-16384), coord_t'(-16384), radius_t'(32), color_t'(32'hFFFF_FFFF));
    send_circle(coord_t'(16383), coord_t'(16383), radius_t'(32), color_t'(32'hA5A5_A5A5));
    send_circle(coord_t'(16383), coord_t'(-16384), radius_t'(1), color_t'(32'h5A5A_5A5A));
    send_circle(coord_t'(-16384), coord_t'(16383), radius_t'(0), color_t'(32'hFF00_00FF));
    send_circle(coord_t'(-1), coord_t'(-1), radius_t'(2), color_t'(32'h00FF_FF00));
    send_circle(coord_t'(5), coord_t'(-7), radius_t'(3), color_t'(32'h1234_5678));
    send_circle(coord_t'(100), coord_t'(200), radius_t'(31), color_t'(32'h8000_0001));
    send_circle(coord_t'(-16384), coord_t'(-16384), radius_t'(33), color_t'(32'h7FFF_FFFE));
    send_circle(coord_t'(16383), coord_t'(16383), radius_t'(63), color_t'(32'hDEAD_BEEF));
    send_circle(coord_t'(1), coord_t'(1), radius_t'(1), color_t'(32'hFFFF_FFFF));
    send_circle(coord_t'(-16383), coord_t'(16382), radius_t'(4), color_t'(32'h0F0F_0F0F));
    req_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk);

    // random bursts with random gaps
    sent = 0;
    while (sent < RANDOM_CIRCLES) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < RANDOM_CIRCLES; i++) begin
        send_random_circle();
        sent++;
      end
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 4);
        2: gap = $urandom_range(5, 40);
        default: gap = $urandom_range(40, 130);
      endcase
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b0;

    // drain
    while (sb.expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_spans.size() != 0) begin
      $error("%0d expected spans never arrived", sb.expected_spans.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
